// ----- src/scls_pkg.sv -----
// Package with the shared types and constants of the serial command LED sequencer.
package scls_pkg;

    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_0      = 8'h30;
    localparam logic [7:0]  CHAR_9      = 8'h39;
    localparam logic [7:0]  CMD_RGB     = 8'h31;
    localparam logic [7:0]  CMD_LEFT    = 8'h32;
    localparam logic [7:0]  CMD_RIGHT   = 8'h33;
    localparam logic [7:0]  CMD_ENTRY   = 8'h34;
    localparam logic [7:0]  CMD_CLR_BAR = 8'h36;
    localparam logic [7:0]  CMD_CLR_ALL = 8'h37;

    localparam logic [15:0] DELAY_RESET = 16'd500;
    localparam logic [15:0] DELAY_MAX   = 16'hFFFF;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    typedef enum logic [2:0] {
        OP_RGB,
        OP_LEFT,
        OP_RIGHT,
        OP_CLR_BAR,
        OP_CLR_ALL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] delay;
    } t_cmd;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

endpackage

// ----- src/scls_front.sv -----
// Front end: accepts serial bytes, tracks entry mode and the delay, and classifies commands.
module scls_front
    import scls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_q_full,
    output logic        o_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic        r_entry;
    logic        n_entry;
    logic [15:0] r_delay;
    logic [15:0] n_delay;
    logic        accept;
    logic        is_digit;
    logic [19:0] scaled;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign is_digit = (i_rx_byte >= CHAR_0) && (i_rx_byte <= CHAR_9);
    assign scaled   = {1'b0, r_delay, 3'b000} + {3'b000, r_delay, 1'b0}
                    + {16'd0, 4'(i_rx_byte - CHAR_0)};

    always_comb begin
        n_entry     = r_entry;
        n_delay     = r_delay;
        o_q_push    = 1'b0;
        o_q_cmd.op  = OP_CLR_BAR;
        o_q_cmd.delay = r_delay;
        if (accept) begin
            if (r_entry) begin
                if (i_rx_byte == CHAR_CR) begin
                    n_entry = 1'b0;
                end else if (is_digit) begin
                    n_delay = (scaled > {4'd0, DELAY_MAX}) ? DELAY_MAX : scaled[15:0];
                end
            end else begin
                case (i_rx_byte)
                    CMD_RGB: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = OP_RGB;
                    end
                    CMD_LEFT: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = OP_LEFT;
                    end
                    CMD_RIGHT: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = OP_RIGHT;
                    end
                    CMD_ENTRY: begin
                        n_entry = 1'b1;
                        n_delay = 16'd0;
                    end
                    CMD_CLR_BAR: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = OP_CLR_BAR;
                    end
                    CMD_CLR_ALL: begin
                        o_q_push   = 1'b1;
                        o_q_cmd.op = OP_CLR_ALL;
                    end
                    default: begin
                        o_q_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= 1'b0;
            r_delay <= DELAY_RESET;
        end else begin
            r_entry <= n_entry;
            r_delay <= n_delay;
        end
    end

endmodule

// ----- src/scls_cmdq.sv -----
// Short command queue between the front end and the sequencer.
module scls_cmdq
    import scls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr;
    logic [CMDQ_PTR_W-1:0] r_rd;
    logic [CMDQ_PTR_W:0]   r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/scls_seq.sv -----
// Back end: expands each queued command into its run of LED writes into the output register.
module scls_seq
    import scls_pkg::*;
#(
    parameter int BAR_WIDTH = 16,
    parameter int RGB_WIDTH = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_cmd                 i_q_cmd,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [BAR_WIDTH-1:0] o_bar_value,
    output logic                 o_bar_write,
    output logic [RGB_WIDTH-1:0] o_rgb_value,
    output logic                 o_rgb_write,
    output logic [15:0]          o_delay_before,
    output logic                 o_last
);

    localparam logic [BAR_WIDTH-1:0] BAR_ONE = BAR_WIDTH'(1);
    localparam logic [BAR_WIDTH-1:0] BAR_MSB = BAR_ONE << (BAR_WIDTH - 1);
    localparam logic [RGB_WIDTH-1:0] RGB_ONE = RGB_WIDTH'(1);

    t_seq_state           r_state;
    t_seq_state           n_state;
    t_op                  r_op;
    t_op                  n_op;
    logic [15:0]          r_delay;
    logic [15:0]          n_delay;
    logic [BAR_WIDTH-1:0] r_bar_walk;
    logic [BAR_WIDTH-1:0] n_bar_walk;
    logic [RGB_WIDTH-1:0] r_rgb_walk;
    logic [RGB_WIDTH-1:0] n_rgb_walk;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [BAR_WIDTH-1:0] r_bar_value;
    logic [BAR_WIDTH-1:0] n_bar_value;
    logic                 r_bar_write;
    logic                 n_bar_write;
    logic [RGB_WIDTH-1:0] r_rgb_value;
    logic [RGB_WIDTH-1:0] n_rgb_value;
    logic                 r_rgb_write;
    logic                 n_rgb_write;
    logic [15:0]          r_delay_before;
    logic [15:0]          n_delay_before;
    logic                 r_last;
    logic                 n_last;

    logic                 out_free;

    assign out_free       = !r_out_valid || i_pop;
    assign o_empty        = !r_out_valid;
    assign o_bar_value    = r_bar_value;
    assign o_bar_write    = r_bar_write;
    assign o_rgb_value    = r_rgb_value;
    assign o_rgb_write    = r_rgb_write;
    assign o_delay_before = r_delay_before;
    assign o_last         = r_last;

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_delay        = r_delay;
        n_bar_walk     = r_bar_walk;
        n_rgb_walk     = r_rgb_walk;
        n_out_valid    = r_out_valid && !i_pop;
        n_bar_value    = r_bar_value;
        n_bar_write    = r_bar_write;
        n_rgb_value    = r_rgb_value;
        n_rgb_write    = r_rgb_write;
        n_delay_before = r_delay_before;
        n_last         = r_last;
        o_q_pop        = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                if (out_free && !i_q_empty) begin
                    o_q_pop        = 1'b1;
                    n_out_valid    = 1'b1;
                    n_op           = i_q_cmd.op;
                    n_delay        = i_q_cmd.delay;
                    n_bar_value    = '0;
                    n_bar_write    = 1'b0;
                    n_rgb_value    = '0;
                    n_rgb_write    = 1'b0;
                    n_delay_before = 16'd0;
                    n_last         = 1'b0;
                    case (i_q_cmd.op)
                        OP_RGB: begin
                            n_rgb_value    = RGB_ONE;
                            n_rgb_write    = 1'b1;
                            n_delay_before = i_q_cmd.delay;
                            n_rgb_walk     = RGB_ONE << 1;
                            n_state        = SEQ_RUN;
                        end
                        OP_LEFT: begin
                            n_bar_value = BAR_ONE;
                            n_bar_write = 1'b1;
                            n_bar_walk  = BAR_ONE << 1;
                            n_state     = SEQ_RUN;
                        end
                        OP_RIGHT: begin
                            n_bar_value = BAR_MSB;
                            n_bar_write = 1'b1;
                            n_bar_walk  = BAR_MSB >> 1;
                            n_state     = SEQ_RUN;
                        end
                        OP_CLR_BAR: begin
                            n_bar_write = 1'b1;
                            n_last      = 1'b1;
                        end
                        OP_CLR_ALL: begin
                            n_bar_write = 1'b1;
                            n_rgb_write = 1'b1;
                            n_last      = 1'b1;
                        end
                        default: begin
                            n_last = 1'b1;
                        end
                    endcase
                end
            end
            SEQ_RUN: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_delay_before = r_delay;
                    if (r_op == OP_RGB) begin
                        n_bar_value = '0;
                        n_bar_write = 1'b0;
                        n_rgb_value = r_rgb_walk;
                        n_rgb_write = 1'b1;
                        n_last      = (r_rgb_walk == '0);
                        n_rgb_walk  = r_rgb_walk << 1;
                    end else begin
                        n_bar_value = r_bar_walk;
                        n_bar_write = 1'b1;
                        n_rgb_value = '0;
                        n_rgb_write = 1'b0;
                        n_last      = (r_bar_walk == '0);
                        n_bar_walk  = (r_op == OP_LEFT) ? (r_bar_walk << 1) : (r_bar_walk >> 1);
                    end
                    if (n_last) begin
                        n_state = SEQ_IDLE;
                    end
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_delay        <= n_delay;
        r_bar_walk     <= n_bar_walk;
        r_rgb_walk     <= n_rgb_walk;
        r_bar_value    <= n_bar_value;
        r_bar_write    <= n_bar_write;
        r_rgb_value    <= n_rgb_value;
        r_rgb_write    <= n_rgb_write;
        r_delay_before <= n_delay_before;
        r_last         <= n_last;
    end

endmodule

// ----- src/serial_command_led_sequencer.sv -----
// Top level of the serial command LED sequencer.
//
// Input channel: one received serial byte per beat on i_rx_byte, taken when i_push is high
// and o_full is low. Result channel: one LED write per beat, shown while o_empty is low and
// taken when i_pop is high. Each write carries the bar or RGB pattern, its write flags, the
// milliseconds to wait before it and a flag on the final beat of the command's run.
// The front end settles entry mode and the delay value in the cycle a byte is taken, so
// bytes may follow one another in every cycle while o_full is low. Commands that produce
// writes go into a four-entry queue; the sequencer turns each into its run at one beat per
// cycle while the receiver takes each beat, so a command yields BAR_WIDTH+1, RGB_WIDTH+1
// or one beat. The first beat of a command is on the result ports in the cycle after the
// sequencer takes it from the queue; the next command can be taken in the cycle the last
// beat of the previous one is taken. o_full rises only with four unstarted commands queued.
// Synchronous reset empties the queue and the output register, sets command mode and a
// delay of 500 ms. When the receiver stalls, the current beat holds, the sequencer waits
// and the queue fills, after which the input side stalls too.
module serial_command_led_sequencer
    import scls_pkg::*;
#(
    parameter int BAR_WIDTH = 16,
    parameter int RGB_WIDTH = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [BAR_WIDTH-1:0] o_bar_value,
    output logic                 o_bar_write,
    output logic [RGB_WIDTH-1:0] o_rgb_value,
    output logic                 o_rgb_write,
    output logic [15:0]          o_delay_before,
    output logic                 o_last
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_wr_cmd;
    t_cmd q_rd_cmd;

    scls_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_full    (o_full),
        .o_q_push  (q_push),
        .o_q_cmd   (q_wr_cmd)
    );

    scls_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_rd_cmd)
    );

    scls_seq #(
        .BAR_WIDTH (BAR_WIDTH),
        .RGB_WIDTH (RGB_WIDTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_rd_cmd),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_bar_value    (o_bar_value),
        .o_bar_write    (o_bar_write),
        .o_rgb_value    (o_rgb_value),
        .o_rgb_write    (o_rgb_write),
        .o_delay_before (o_delay_before),
        .o_last         (o_last)
    );

endmodule

// ----- test/serial_command_led_sequencer_tb.sv -----
// Self-checking testbench for the serial command LED sequencer: directed table, random streams.
module serial_command_led_sequencer_tb
    import scls_pkg::*;
();

    localparam int BAR_W       = 16;
    localparam int RGB_W       = 3;
    localparam int ITEM_TARGET = 410;

    typedef struct packed {
        logic [BAR_W-1:0] bar_value;
        logic             bar_write;
        logic [RGB_W-1:0] rgb_value;
        logic             rgb_write;
        logic [15:0]      delay_before;
        logic             last;
    } t_led_write;

    typedef struct {
        logic [7:0] rx;
        int         n_typed;
        t_led_write typed;
    } t_stim_row;

    localparam t_led_write NO_WRITE      = '0;
    localparam t_led_write CLR_BAR_WRITE = '{16'h0000, 1'b1, 3'h0, 1'b0, 16'h0000, 1'b1};
    localparam t_led_write CLR_ALL_WRITE = '{16'h0000, 1'b1, 3'h0, 1'b1, 16'h0000, 1'b1};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_push;
    logic                o_full;
    logic [7:0]          i_rx_byte;
    logic                o_empty;
    logic                i_pop;
    logic [BAR_W-1:0]    o_bar_value;
    logic                o_bar_write;
    logic [RGB_W-1:0]    o_rgb_value;
    logic                o_rgb_write;
    logic [15:0]         o_delay_before;
    logic                o_last;

    t_led_write  writes_due[$];
    t_stim_row   dir_rows[$];
    logic        model_entry;
    logic [15:0] model_delay;
    int          n_active;
    int          n_errors;
    int          tx_idle_pct;
    int          rx_idle_pct;

    serial_command_led_sequencer #(
        .BAR_WIDTH(BAR_W),
        .RGB_WIDTH(RGB_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_rx_byte     (i_rx_byte),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_bar_value   (o_bar_value),
        .o_bar_write   (o_bar_write),
        .o_rgb_value   (o_rgb_value),
        .o_rgb_write   (o_rgb_write),
        .o_delay_before(o_delay_before),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit led_writes_for(input logic [7:0] c, output t_led_write w[$]);
        int unsigned v;
        t_led_write  b;
        w = {};
        if (model_entry) begin
            if (c == CHAR_CR) begin
                model_entry = 1'b0;
                return 1'b1;
            end
            if (c >= CHAR_0 && c <= CHAR_9) begin
                v = model_delay * 10 + (c - CHAR_0);
                model_delay = (v > DELAY_MAX) ? DELAY_MAX : v[15:0];
                return 1'b1;
            end
            return 1'b0;
        end
        case (c)
            CMD_RGB: begin
                for (int i = 0; i <= RGB_W; i++) begin
                    b = NO_WRITE;
                    b.rgb_write = 1'b1;
                    if (i < RGB_W) b.rgb_value[i] = 1'b1;
                    b.delay_before = model_delay;
                    b.last = (i == RGB_W);
                    w.push_back(b);
                end
            end
            CMD_LEFT, CMD_RIGHT: begin
                for (int i = 0; i <= BAR_W; i++) begin
                    b = NO_WRITE;
                    b.bar_write = 1'b1;
                    if (i < BAR_W) begin
                        if (c == CMD_LEFT) b.bar_value[i] = 1'b1;
                        else b.bar_value[BAR_W-1-i] = 1'b1;
                    end
                    b.delay_before = (i == 0) ? 16'd0 : model_delay;
                    b.last = (i == BAR_W);
                    w.push_back(b);
                end
            end
            CMD_ENTRY: begin
                model_delay = '0;
                model_entry = 1'b1;
            end
            CMD_CLR_BAR: w.push_back(CLR_BAR_WRITE);
            CMD_CLR_ALL: w.push_back(CLR_ALL_WRITE);
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic add_row(input logic [7:0] rx, input int n_typed, input t_led_write typed);
        t_stim_row r;
        r.rx = rx;
        r.n_typed = n_typed;
        r.typed = typed;
        dir_rows.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit use_model);
        t_led_write w[$];
        while ($urandom_range(99) < tx_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_full);
        void'(led_writes_for(b, w));
        n_active++;
        if (use_model) begin
            foreach (w[k]) writes_due.push_back(w[k]);
        end
    endtask

    task automatic wait_all_written();
        i_push <= 1'b0;
        do @(posedge i_clk); while (writes_due.size() != 0);
    endtask

    initial begin : stimulus
        int         phase;
        int         pick;
        int         n_digits;
        logic [7:0] b;
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_rx_byte   = '0;
        i_pop       = 1'b0;
        model_entry = 1'b0;
        model_delay = DELAY_RESET;
        n_active    = 0;
        n_errors    = 0;
        tx_idle_pct = 9;
        rx_idle_pct = 75;
        phase       = 0;

        add_row(CMD_RGB,     -1, NO_WRITE);
        add_row(CMD_LEFT,    -1, NO_WRITE);
        add_row(CMD_RIGHT,   -1, NO_WRITE);
        add_row(CMD_CLR_BAR,  1, CLR_BAR_WRITE);
        add_row(CMD_CLR_ALL,  1, CLR_ALL_WRITE);
        add_row(8'h35,        0, NO_WRITE);
        add_row(8'h38,        0, NO_WRITE);
        add_row(8'h00,        0, NO_WRITE);
        add_row(8'hFF,        0, NO_WRITE);
        add_row(CHAR_CR,      0, NO_WRITE);
        add_row(CMD_ENTRY,    0, NO_WRITE);
        repeat (5) add_row(CHAR_9, 0, NO_WRITE);
        add_row(8'h61,        0, NO_WRITE);
        add_row(CMD_ENTRY,    0, NO_WRITE);
        add_row(CHAR_CR,      0, NO_WRITE);
        add_row(CMD_RGB,     -1, NO_WRITE);
        add_row(CMD_ENTRY,    0, NO_WRITE);
        add_row(CHAR_0,       0, NO_WRITE);
        add_row(CHAR_CR,      0, NO_WRITE);
        add_row(CMD_RIGHT,   -1, NO_WRITE);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_byte(dir_rows[k].rx, dir_rows[k].n_typed < 0);
            if (dir_rows[k].n_typed > 0) writes_due.push_back(dir_rows[k].typed);
        end

        while (n_active < ITEM_TARGET) begin
            if (phase == 0 && n_active >= ITEM_TARGET / 3) begin
                wait_all_written();
                phase = 1;
                tx_idle_pct = 75;
                rx_idle_pct = 9;
            end else if (phase == 1 && n_active >= 2 * ITEM_TARGET / 3) begin
                wait_all_written();
                phase = 2;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_byte(8'($urandom_range(255)), 1'b1);
            end else if (pick < 28) begin
                send_byte(CMD_ENTRY, 1'b1);
                n_digits = $urandom_range(6);
                repeat (n_digits) begin
                    if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)), 1'b1);
                    send_byte(CHAR_0 + 8'($urandom_range(9)), 1'b1);
                end
                if ($urandom_range(9) != 0) send_byte(CHAR_CR, 1'b1);
            end else begin
                case ($urandom_range(4))
                    0:       b = CMD_RGB;
                    1:       b = CMD_LEFT;
                    2:       b = CMD_RIGHT;
                    3:       b = CMD_CLR_BAR;
                    default: b = CMD_CLR_ALL;
                endcase
                send_byte(b, 1'b1);
            end
        end

        wait_all_written();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && writes_due.size() == 0) begin
            $display("serial_command_led_sequencer_tb: PASS");
        end else begin
            $display("serial_command_led_sequencer_tb: FAIL");
        end
        $finish;
    end

    initial begin : check_results
        t_led_write got;
        t_led_write want;
        wait (i_rst_n === 1'b1);
        forever begin
            i_pop <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                got = '{o_bar_value, o_bar_write, o_rgb_value, o_rgb_write,
                        o_delay_before, o_last};
                if (writes_due.size() == 0) begin
                    $error("result beat with nothing expected: %h", got);
                    n_errors++;
                end else begin
                    want = writes_due.pop_front();
                    if (got.bar_value !== want.bar_value) begin
                        $error("bar_value: expected %h, got %h", want.bar_value, got.bar_value);
                        n_errors++;
                    end
                    if (got.bar_write !== want.bar_write) begin
                        $error("bar_write: expected %b, got %b", want.bar_write, got.bar_write);
                        n_errors++;
                    end
                    if (got.rgb_value !== want.rgb_value) begin
                        $error("rgb_value: expected %h, got %h", want.rgb_value, got.rgb_value);
                        n_errors++;
                    end
                    if (got.rgb_write !== want.rgb_write) begin
                        $error("rgb_write: expected %b, got %b", want.rgb_write, got.rgb_write);
                        n_errors++;
                    end
                    if (got.delay_before !== want.delay_before) begin
                        $error("delay_before: expected %0d, got %0d",
                               want.delay_before, got.delay_before);
                        n_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("serial_command_led_sequencer_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/scls_pkg.sv
src/scls_front.sv
src/scls_cmdq.sv
src/scls_seq.sv
src/serial_command_led_sequencer.sv
test/serial_command_led_sequencer_tb.sv
